// ===== hw/rtl/dopl_pkg.sv =====
// ----------------------------------------------------------------------------
// dopl_pkg
// Shared types and constants for the open-page DRAM row-buffer latency block.
// ----------------------------------------------------------------------------
package dopl_pkg;

  // Fixed field widths
  localparam int ADDR_W      = 32;
  localparam int LAT_W       = 10;
  localparam int ROW_MAX_W   = 16;
  localparam int POS_W       = 7;   // holds any field position up to 127
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  // Parameter defaults
  localparam int DEF_ADDR_BITS     = 32;
  localparam int DEF_RANK_BITS     = 1;
  localparam int DEF_COL_LOW_BITS  = 2;
  localparam int DEF_COL_HIGH_BITS = 2;
  localparam int DEF_MAX_DIMM_BITS = 1;
  localparam int DEF_MAX_BANK_BITS = 3;

  // Configuration register reset values
  localparam logic [4:0] RST_OFFSET_BITS = 5'd20;
  localparam logic       RST_DIMM_BITS   = 1'b1;
  localparam logic [1:0] RST_BANK_BITS   = 2'd3;
  localparam logic [4:0] RST_ROW_BITS    = 5'd4;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_BITS        = 3'd0,
    REG_DIMM_BITS          = 3'd1,
    REG_BANK_BITS          = 3'd2,
    REG_ROW_BITS           = 3'd3,
    REG_READ_HIT_LATENCY   = 3'd4,
    REG_WRITE_HIT_LATENCY  = 3'd5,
    REG_READ_MISS_LATENCY  = 3'd6,
    REG_WRITE_MISS_LATENCY = 3'd7
  } cfg_reg_t;

  // Access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture a new transaction
    logic decode;   // split address into table index and row
    logic update;   // look up bank, compare, update, present result
  } dopl_cmd_t;

endpackage

// ===== hw/rtl/dopl_ctrl.sv =====
// ----------------------------------------------------------------------------
// dopl_ctrl
// Sequencer: steps each transaction through capture, decode and lookup.
// ----------------------------------------------------------------------------
module dopl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output dopl_pkg::dopl_cmd_t cmd
);
  import dopl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_LOOKUP
  } state_t;

  state_t state;

  // State and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_DECODE;
            busy  <= 1'b1;
          end
        end
        S_DECODE: begin
          state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd.load   = start && !busy;
    cmd.decode = (state == S_DECODE);
    cmd.update = (state == S_LOOKUP);
  end

endmodule

// ===== hw/rtl/dopl_dp.sv =====
// ----------------------------------------------------------------------------
// dopl_dp
// Datapath: configuration registers, address decode, open-row table and
// result registers.
// ----------------------------------------------------------------------------
module dopl_dp #(
  parameter int ADDR_BITS     = dopl_pkg::DEF_ADDR_BITS,
  parameter int RANK_BITS     = dopl_pkg::DEF_RANK_BITS,
  parameter int COL_LOW_BITS  = dopl_pkg::DEF_COL_LOW_BITS,
  parameter int COL_HIGH_BITS = dopl_pkg::DEF_COL_HIGH_BITS,
  parameter int MAX_DIMM_BITS = dopl_pkg::DEF_MAX_DIMM_BITS,
  parameter int MAX_BANK_BITS = dopl_pkg::DEF_MAX_BANK_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dopl_pkg::dopl_cmd_t              cmd,
  input  logic                             kind,
  input  logic [dopl_pkg::ADDR_W-1:0]      address,
  input  logic                             cfg_write,
  input  logic [dopl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dopl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             done,
  output logic [dopl_pkg::LAT_W-1:0]       latency,
  output logic                             row_hit
);
  import dopl_pkg::*;

  localparam int IDX_SUM = MAX_DIMM_BITS + RANK_BITS + MAX_BANK_BITS;
  localparam int IDX_W   = (IDX_SUM > 0) ? IDX_SUM : 1;
  localparam int DEPTH   = 1 << IDX_W;

  // Configuration registers
  logic [4:0]       offset_bits;
  logic             dimm_bits;
  logic [1:0]       bank_bits;
  logic [4:0]       row_bits;
  logic [LAT_W-1:0] read_hit_latency;
  logic [LAT_W-1:0] write_hit_latency;
  logic [LAT_W-1:0] read_miss_latency;
  logic [LAT_W-1:0] write_miss_latency;

  // Captured transaction
  logic              kind_q;
  logic [ADDR_W-1:0] addr_q;

  // Decoded lookup
  logic                 kind_d;
  logic [IDX_W-1:0]     idx;
  logic [ROW_MAX_W-1:0] row;

  // Open-row table
  logic [ROW_MAX_W-1:0] open_row [DEPTH];
  logic [DEPTH-1:0]     row_valid;

  // Decode signals
  logic [ADDR_W-1:0] addr_mask;
  logic [ADDR_W-1:0] addr_m;
  logic [POS_W-1:0]  pos_dimm, pos_bank, pos_rank, pos_row;
  logic [1:0]        dimm_w, bank_w;
  logic [4:0]        row_w;
  logic [ADDR_W-1:0] dimm_v, bank_v, rank_v, row_v, idx_full;
  logic [IDX_W-1:0]  idx_next;
  logic [ROW_MAX_W-1:0] row_next;
  logic              hit;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits        <= RST_OFFSET_BITS;
      dimm_bits          <= RST_DIMM_BITS;
      bank_bits          <= RST_BANK_BITS;
      row_bits           <= RST_ROW_BITS;
      read_hit_latency   <= '0;
      write_hit_latency  <= '0;
      read_miss_latency  <= '0;
      write_miss_latency <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OFFSET_BITS:        offset_bits        <= cfg_data[4:0];
        REG_DIMM_BITS:          dimm_bits          <= cfg_data[0];
        REG_BANK_BITS:          bank_bits          <= cfg_data[1:0];
        REG_ROW_BITS:           row_bits           <= cfg_data[4:0];
        REG_READ_HIT_LATENCY:   read_hit_latency   <= cfg_data[LAT_W-1:0];
        REG_WRITE_HIT_LATENCY:  write_hit_latency  <= cfg_data[LAT_W-1:0];
        REG_READ_MISS_LATENCY:  read_miss_latency  <= cfg_data[LAT_W-1:0];
        REG_WRITE_MISS_LATENCY: write_miss_latency <= cfg_data[LAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      addr_q <= address;
    end
  end

  // Address decode: bits at or above ADDR_BITS read as zero
  always_comb begin
    for (int i = 0; i < ADDR_W; i++) begin
      addr_mask[i] = (i < ADDR_BITS);
    end
    addr_m = addr_q & addr_mask;

    pos_dimm = POS_W'(offset_bits);
    pos_bank = pos_dimm + POS_W'(dimm_bits) + POS_W'(COL_LOW_BITS);
    pos_rank = pos_bank + POS_W'(bank_bits) + POS_W'(COL_HIGH_BITS);
    pos_row  = pos_rank + POS_W'(RANK_BITS);

    // Wide fields keep their layout width but select with fewer bits
    dimm_w = (2'(dimm_bits) < 2'(MAX_DIMM_BITS)) ? 2'(dimm_bits) : 2'(MAX_DIMM_BITS);
    bank_w = (bank_bits < 2'(MAX_BANK_BITS)) ? bank_bits : 2'(MAX_BANK_BITS);
    if (MAX_BANK_BITS > 3) begin
      bank_w = bank_bits;
    end
    row_w  = (row_bits > 5'(ROW_MAX_W)) ? 5'(ROW_MAX_W) : row_bits;

    dimm_v = (addr_m >> pos_dimm) & ((ADDR_W'(1) << dimm_w) - ADDR_W'(1));
    bank_v = (addr_m >> pos_bank) & ((ADDR_W'(1) << bank_w) - ADDR_W'(1));
    rank_v = (addr_m >> pos_rank) & ((ADDR_W'(1) << RANK_BITS) - ADDR_W'(1));
    row_v  = (addr_m >> pos_row)  & ((ADDR_W'(1) << row_w) - ADDR_W'(1));

    idx_full = (dimm_v << (RANK_BITS + MAX_BANK_BITS)) | (rank_v << MAX_BANK_BITS) | bank_v;
    idx_next = IDX_W'(idx_full);
    row_next = row_v[ROW_MAX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      kind_d <= kind_q;
      idx    <= idx_next;
      row    <= row_next;
    end
  end

  // Lookup and compare
  assign hit = row_valid[idx] && (open_row[idx] == row);

  // Table update on a miss
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.update && !hit) begin
      row_valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && !hit) begin
      open_row[idx] <= row;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      row_hit <= hit;
      if (hit) begin
        latency <= (kind_d == KIND_WRITE) ? write_hit_latency : read_hit_latency;
      end else begin
        latency <= (kind_d == KIND_WRITE) ? write_miss_latency : read_miss_latency;
      end
    end
  end

endmodule

// ===== hw/rtl/dram_open_page_latency.sv =====
// ----------------------------------------------------------------------------
// dram_open_page_latency
// Open-page row-buffer model: tracks the open row per bank and reports the
// configured hit or miss latency for each access.
//
//   Channel   Signals                              Handshake
//   -------   ----------------------------------   ------------------------
//   access    kind, address                        start && !busy
//   result    latency, row_hit                     done, one-cycle strobe
//   config    cfg_write, cfg_index, cfg_data       cfg_write, no wait
//
// Each transaction steps through capture, address decode into bank index
// and row, then table lookup with compare and update; done pulses in the
// cycle after the lookup. busy is high for the decode and lookup cycles, so
// a new access can be taken while the last result is still on the outputs.
// Reset (rst, synchronous) clears all open-row valid bits at once and loads
// the configuration defaults. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module dram_open_page_latency #(
  parameter int ADDR_BITS     = dopl_pkg::DEF_ADDR_BITS,
  parameter int RANK_BITS     = dopl_pkg::DEF_RANK_BITS,
  parameter int COL_LOW_BITS  = dopl_pkg::DEF_COL_LOW_BITS,
  parameter int COL_HIGH_BITS = dopl_pkg::DEF_COL_HIGH_BITS,
  parameter int MAX_DIMM_BITS = dopl_pkg::DEF_MAX_DIMM_BITS,
  parameter int MAX_BANK_BITS = dopl_pkg::DEF_MAX_BANK_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             kind,
  input  logic [dopl_pkg::ADDR_W-1:0]      address,
  input  logic                             cfg_write,
  input  logic [dopl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dopl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             done,
  output logic [dopl_pkg::LAT_W-1:0]       latency,
  output logic                             row_hit
);
  import dopl_pkg::*;

  dopl_cmd_t cmd;

  // Sequencer
  dopl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath
  dopl_dp #(
    .ADDR_BITS     (ADDR_BITS),
    .RANK_BITS     (RANK_BITS),
    .COL_LOW_BITS  (COL_LOW_BITS),
    .COL_HIGH_BITS (COL_HIGH_BITS),
    .MAX_DIMM_BITS (MAX_DIMM_BITS),
    .MAX_BANK_BITS (MAX_BANK_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .kind      (kind),
    .address   (address),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .latency   (latency),
    .row_hit   (row_hit)
  );

endmodule
